/* hdl/priority_counting_semaphore_unit_defines.svh */
// Assertion macros shared by the semaphore checker.
`ifndef PRIORITY_COUNTING_SEMAPHORE_UNIT_DEFINES_SVH
`define PRIORITY_COUNTING_SEMAPHORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PSEM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSEM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/psem_pkg.sv */
// Shared constants and types for the priority counting semaphore.
`timescale 1ns / 1ps
`default_nettype none

package psem_pkg;

   localparam int MAX_WAITERS   = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int TASK_ID_BITS  = 5;
   localparam int OCC_BITS      = $clog2(MAX_WAITERS + 1);
   localparam int COUNT_BITS    = 16;
   localparam int INIT_BITS     = 15;

   localparam logic REQ_WAIT = 1'b0;
   localparam logic REQ_POST = 1'b1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

   typedef struct packed {
      logic                     req_type;
      logic [TASK_ID_BITS-1:0]  task_id;
      logic [PRIORITY_BITS-1:0] task_priority;
      logic                     has_current;
      logic [PRIORITY_BITS-1:0] current_priority;
   } psem_req_type;

   typedef struct packed {
      logic                         acquired;
      logic                         blocked;
      logic                         queue_overflow;
      logic                         count_saturated;
      logic                         wake_valid;
      logic [TASK_ID_BITS-1:0]      woken_task;
      logic                         preempt;
      logic signed [COUNT_BITS-1:0] count_now;
   } psem_rsp_type;

   typedef struct packed {
      logic capture;   // load the request register
      logic execute;   // apply the request, load the result register
   } psem_cmd_type;

endpackage

`default_nettype wire

/* hdl/psem_ctrl.sv */
// Controller: request/result handshake sequencing for the semaphore.
`timescale 1ns / 1ps
`default_nettype none

module psem_ctrl
   import psem_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output psem_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      out_free    = !rsp_valid_ff || !rsp_stall;
      cmd.capture = req_valid && !req_stall;
      cmd.execute = (state_ff == ST_EXEC) && out_free;

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (cmd.execute) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // hold a stalled result, load a fresh one on execute
      rsp_valid_in = cmd.execute || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hdl/psem_dp.sv */
// Datapath: count register, sorted shift-register wait queue, result register.
`timescale 1ns / 1ps
`default_nettype none

module psem_dp
   import psem_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire psem_cmd_type         cmd,
   input  wire psem_req_type         req_payload,
   input  wire logic                 csr_wr_en,
   input  wire logic [INIT_BITS-1:0] csr_wr_data,
   output psem_rsp_type              rsp_payload
);

   psem_req_type req_ff;
   psem_rsp_type rsp_ff, rsp_in;

   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [OCC_BITS-1:0]      occ_ff, occ_in;
   logic [TASK_ID_BITS-1:0]  ids_ff   [MAX_WAITERS];
   logic [TASK_ID_BITS-1:0]  ids_in   [MAX_WAITERS];
   logic [PRIORITY_BITS-1:0] prios_ff [MAX_WAITERS];
   logic [PRIORITY_BITS-1:0] prios_in [MAX_WAITERS];

   // stay_mask[i+1]: entry i holds a live waiter that goes ahead of the new one
   logic [MAX_WAITERS:0]  stay_mask;
   logic [COUNT_BITS-1:0] count_dec, count_inc;

   always_comb begin
      int src;
      src       = 0;
      count_dec = count_ff - COUNT_BITS'(1);
      count_inc = count_ff + COUNT_BITS'(1);
      count_in  = count_ff;
      occ_in    = occ_ff;
      ids_in    = ids_ff;
      prios_in  = prios_ff;
      rsp_in    = '0;

      stay_mask[0] = 1'b1;
      for (int i = 0; i < MAX_WAITERS; i++) begin
         stay_mask[i+1] = (OCC_BITS'(i) < occ_ff) &&
                          (prios_ff[i] <= req_ff.task_priority);
      end

      if (req_ff.req_type == REQ_WAIT) begin
         if (!count_ff[COUNT_BITS-1] && (count_ff != '0)) begin
            count_in        = count_dec;
            rsp_in.acquired = 1'b1;
         end else if ((occ_ff == OCC_BITS'(MAX_WAITERS)) || (count_ff == COUNT_MIN)) begin
            rsp_in.queue_overflow = 1'b1;
         end else begin
            count_in       = count_dec;
            occ_in         = occ_ff + OCC_BITS'(1);
            rsp_in.blocked = 1'b1;
            // keep entries ahead, drop the new one in, shift the rest back
            for (int i = 0; i < MAX_WAITERS; i++) begin
               src = (i == 0) ? 0 : i - 1;
               if (!stay_mask[i+1]) begin
                  if (stay_mask[i]) begin
                     ids_in[i]   = req_ff.task_id;
                     prios_in[i] = req_ff.task_priority;
                  end else begin
                     ids_in[i]   = ids_ff[src];
                     prios_in[i] = prios_ff[src];
                  end
               end
            end
         end
      end else begin
         if (count_ff == COUNT_MAX) begin
            rsp_in.count_saturated = 1'b1;
         end else begin
            count_in = count_inc;
            if (count_ff[COUNT_BITS-1] && (occ_ff != '0)) begin
               rsp_in.wake_valid = 1'b1;
               rsp_in.woken_task = ids_ff[0];
               rsp_in.preempt    = req_ff.has_current &&
                                   (prios_ff[0] < req_ff.current_priority);
               occ_in            = occ_ff - OCC_BITS'(1);
               // advance every waiter one place toward the head
               for (int i = 0; i < MAX_WAITERS - 1; i++) begin
                  ids_in[i]   = ids_ff[i+1];
                  prios_in[i] = prios_ff[i+1];
               end
            end
         end
      end

      rsp_in.count_now = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         occ_ff   <= '0;
      end else if (csr_wr_en) begin
         count_ff <= {1'b0, csr_wr_data};
         occ_ff   <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.execute) begin
         ids_ff   <= ids_in;
         prios_ff <= prios_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* hdl/priority_counting_semaphore_unit.sv */
// Top level of the priority counting semaphore with a sorted wait queue.
// An item accepted into the request register is applied in EXEC once the result
// register is free; no new item is accepted until then, as the request register
//   holds one item and the apply step runs through the shift-register queue.
// A result waiting on rsp_stall does not block the next item from entering.
// Reset (synchronous, active high): count 0, queue empty, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module priority_counting_semaphore_unit
   import psem_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire psem_req_type         req_payload,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output psem_rsp_type              rsp_payload,
   // initial count register; a write reloads the count and empties the queue
   input  wire logic                 csr_wr_en,
   input  wire logic [INIT_BITS-1:0] csr_wr_data
);

   psem_cmd_type cmd;

   // Controller: two states. IDLE takes an item into the request register;
   // EXEC applies it as soon as the result register is free (empty, or its
   // item is being taken this cycle), then returns to IDLE.
   psem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Datapath: the count, the wait queue kept sorted by priority (head at
   // entry 0, equal priorities in arrival order) and the result register.
   // Insert compares every live entry against the new priority in parallel
   // and shifts the tail back by one; a wake shifts the whole queue forward.
   psem_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* hdl/psem_checker.sv */
// Port-level checker for the semaphore, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "priority_counting_semaphore_unit_defines.svh"

module psem_checker
   import psem_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire psem_req_type         req_payload,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire psem_rsp_type         rsp_payload,
   input wire logic                 csr_wr_en,
   input wire logic [INIT_BITS-1:0] csr_wr_data
);

   `PSEM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")

   `PSEM_ASSERT_NOW(a_one_outcome, rsp_valid, $onehot0({rsp_payload.acquired, rsp_payload.blocked, rsp_payload.queue_overflow, rsp_payload.count_saturated, rsp_payload.wake_valid}), "more than one outcome flag")

   `PSEM_ASSERT_NOW(a_no_wake_clean, rsp_valid && !rsp_payload.wake_valid, (rsp_payload.woken_task == '0) && !rsp_payload.preempt, "wake fields set without a wake")

   `PSEM_ASSERT_NOW(a_count_sign, rsp_valid && (rsp_payload.acquired || rsp_payload.blocked), rsp_payload.count_now[COUNT_BITS-1] == rsp_payload.blocked, "count sign disagrees with wait outcome")

endmodule

bind priority_counting_semaphore_unit psem_checker u_psem_checker (.*);

`default_nettype wire
